/* src/tmog_pkg.sv */
// Shared types, register indexes and reset constants for the thermostat
// minimum-off guard. No dependencies; every other file imports this package.
package tmog_pkg;

  // Field and register widths
  localparam int TEMP_W    = 12;
  localparam int DIFF_W    = 11;
  localparam int SECONDS_W = 16;
  localparam int ELAPSED_W = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam int unsigned TICKS_PER_SECOND_DEF = 1000;
  localparam int unsigned ELAPSED_MAX = (1 << ELAPSED_W) - 1;

  // Reset values of the configuration registers
  localparam logic signed [TEMP_W-1:0] SETPOINT_RST     = 12'sd64;
  localparam logic        [DIFF_W-1:0] DIFFERENTIAL_RST = 11'd32;
  localparam logic     [SECONDS_W-1:0] MIN_OFF_RST      = 16'd180;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFERENTIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OFF      = 2'd2;

  // Item kinds
  localparam logic ACT_EVALUATE = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [TEMP_W-1:0] temperature;
    logic                     temp_valid;
  } tmog_item_t;

  // Stored control flags; also the shape of one result
  typedef struct packed {
    logic                 relay;
    logic                 demand;
    logic                 permit;
    logic [SECONDS_W-1:0] wait_sec;
  } tmog_flags_t;

  typedef struct packed {
    logic tick;
    logic expire;
    logic restart;
  } tmog_guard_cmd_t;

  typedef struct packed {
    logic                 active;
    logic [ELAPSED_W-1:0] sec_count;
  } tmog_guard_stat_t;

endpackage

/* src/tmog_guard.sv */
// Minimum-off guard timer: active flag plus elapsed time kept as whole
// seconds and a sub-second tick count. Depends on tmog_pkg.
module tmog_guard #(
  parameter int unsigned TICKS_PER_SECOND = tmog_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  tmog_pkg::tmog_guard_cmd_t  cmd,
  output tmog_pkg::tmog_guard_stat_t stat
);
  import tmog_pkg::*;

  localparam int SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int unsigned SAT_SEC = ELAPSED_MAX / TICKS_PER_SECOND;
  localparam int unsigned SAT_SUB = ELAPSED_MAX % TICKS_PER_SECOND;
  localparam logic [SUB_W-1:0]     SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);
  localparam logic [SUB_W-1:0]     SAT_SUB_V = SUB_W'(SAT_SUB);
  localparam logic [ELAPSED_W-1:0] SAT_SEC_V = ELAPSED_W'(SAT_SEC);

  logic                 active;
  logic [ELAPSED_W-1:0] sec_count;
  logic [SUB_W-1:0]     sub_count;
  logic                 saturated;

  // Elapsed ticks stop at the counter ceiling
  assign saturated = (sec_count == SAT_SEC_V) && (sub_count == SAT_SUB_V);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b1;
      sec_count <= '0;
      sub_count <= '0;
    end else if (step) begin
      if (cmd.restart) begin
        active    <= 1'b1;
        sec_count <= '0;
        sub_count <= '0;
      end else if (cmd.expire) begin
        active <= 1'b0;
      end else if (cmd.tick && active && !saturated) begin
        if (sub_count == SUB_LAST) begin
          sub_count <= '0;
          sec_count <= sec_count + 1'b1;
        end else begin
          sub_count <= sub_count + 1'b1;
        end
      end
    end
  end

  assign stat.active    = active;
  assign stat.sec_count = sec_count;

endmodule

/* src/tmog_ctrl.sv */
// Next-state logic for one item: hysteresis demand, guard check and relay
// decision. Pure combinational; depends on tmog_pkg.
module tmog_ctrl (
  input  tmog_pkg::tmog_item_t                       item,
  input  tmog_pkg::tmog_flags_t                      flags,
  input  tmog_pkg::tmog_guard_stat_t                 guard,
  input  logic signed [tmog_pkg::TEMP_W-1:0]         setpoint,
  input  logic        [tmog_pkg::DIFF_W-1:0]         differential,
  input  logic        [tmog_pkg::SECONDS_W-1:0]      off_time_sec,
  output tmog_pkg::tmog_flags_t                      flags_next,
  output tmog_pkg::tmog_guard_cmd_t                  cmd
);
  import tmog_pkg::*;

  logic signed [TEMP_W:0]  temp_x;
  logic signed [TEMP_W:0]  sp_x;
  logic signed [TEMP_W:0]  cut_in;
  logic [ELAPSED_W-1:0]    span_sec;
  logic [ELAPSED_W-1:0]    left_sec;
  logic                    blocked;
  logic                    demand_n;
  logic                    permit_n;
  logic                    relay_n;

  assign temp_x   = {item.temperature[TEMP_W-1], item.temperature};
  assign sp_x     = {setpoint[TEMP_W-1], setpoint};
  assign cut_in   = sp_x + $signed({2'b00, differential});
  assign span_sec = {{(ELAPSED_W-SECONDS_W){1'b0}}, off_time_sec};
  // Ceil of remaining ticks over ticks per second equals whole seconds left
  assign left_sec = span_sec - guard.sec_count;
  assign blocked  = guard.active && (guard.sec_count < span_sec);

  always_comb begin
    flags_next = flags;
    cmd        = '0;
    demand_n   = flags.demand;
    permit_n   = 1'b1;
    relay_n    = 1'b0;
    case (item.action)
      ACT_TICK: begin
        cmd.tick = 1'b1;
      end
      default: begin
        if (item.temp_valid) begin
          if (temp_x >= cut_in) begin
            demand_n = 1'b1;
          end else if (temp_x <= sp_x) begin
            demand_n = 1'b0;
          end
          permit_n = !blocked;
          cmd.expire = guard.active && !blocked;
          relay_n = demand_n && permit_n;
          flags_next.demand   = demand_n;
          flags_next.relay    = relay_n;
          flags_next.permit   = permit_n;
          flags_next.wait_sec = blocked ? left_sec[SECONDS_W-1:0] : '0;
          // Relay drop restarts the guard
          if (flags.relay && !relay_n) begin
            cmd.restart         = 1'b1;
            flags_next.permit   = 1'b0;
            flags_next.wait_sec = off_time_sec;
          end
        end else begin
          flags_next = '0;
        end
      end
    endcase
  end

endmodule

/* src/thermostat_min_off_guard_core.sv */
// Path: each input transfer lands in the input register, then its result in the
// result register once that is free or draining, so two register stages in all.
// Throughput: one item per cycle; a result held by m_tready low stalls s_tready
// once the input register is also full. Reset (rst, synchronous): relay, demand
// and permit off, guard running from zero elapsed, wait 180 s, registers back
// to setpoint 64, differential 32, minimum off 180 s. Uses tmog_pkg, tmog_ctrl, tmog_guard.
module thermostat_min_off_guard_core #(
  parameter int unsigned TICKS_PER_SECOND = tmog_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [11:0] temperature, [12] temp_valid, [15:13] zero
  input  logic [tmog_pkg::IN_DATA_W-1:0]    s_tdata,
  // [0] action (0 evaluate, 1 tick)
  input  logic                              s_tuser,
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] relay, [1] should_be_on, [2] can_turn_on, [18:3] wait_seconds,
  // [23:19] zero
  output logic [tmog_pkg::OUT_DATA_W-1:0]   m_tdata,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [tmog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmog_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tmog_pkg::*;

  // Configuration registers
  logic signed [TEMP_W-1:0] setpoint;
  logic [DIFF_W-1:0]        differential;
  logic [SECONDS_W-1:0]     off_time_sec;

  // Input register
  logic       in_valid;
  tmog_item_t in_item;

  // Control state and result register
  tmog_flags_t      flags;
  tmog_flags_t      flags_next;
  tmog_flags_t      result;
  tmog_guard_cmd_t  guard_cmd;
  tmog_guard_stat_t guard_stat;
  logic             advance;

  // Move the held item on whenever the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= SETPOINT_RST;
      differential <= DIFFERENTIAL_RST;
      off_time_sec <= MIN_OFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:     setpoint     <= $signed(cfg_data[TEMP_W-1:0]);
        REG_DIFFERENTIAL: differential <= cfg_data[DIFF_W-1:0];
        REG_MIN_OFF:      off_time_sec <= cfg_data[SECONDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action      <= s_tuser;
      in_item.temperature <= $signed(s_tdata[TEMP_W-1:0]);
      in_item.temp_valid  <= s_tdata[TEMP_W];
    end
  end

  tmog_ctrl u_ctrl (
    .item         (in_item),
    .flags        (flags),
    .guard        (guard_stat),
    .setpoint     (setpoint),
    .differential (differential),
    .off_time_sec (off_time_sec),
    .flags_next   (flags_next),
    .cmd          (guard_cmd)
  );

  tmog_guard #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_guard (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (guard_cmd),
    .stat (guard_stat)
  );

  // Update stored flags as each item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      flags.relay    <= 1'b0;
      flags.demand   <= 1'b0;
      flags.permit   <= 1'b0;
      flags.wait_sec <= MIN_OFF_RST;
    end else if (advance) begin
      flags <= flags_next;
    end
  end

  // Result register: hold until the downstream side takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= flags_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-SECONDS_W-3){1'b0}}, result.wait_sec,
                    result.permit, result.demand, result.relay};

endmodule

/* tb/sv/thermostat_min_off_guard_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for thermostat_min_off_guard_core: directed and random item streams
// with random idling, each result checked against an in-bench thermostat predictor.
// Depends on tmog_pkg and the core RTL; needs no files or arguments.
module thermostat_min_off_guard_core_tb;
  import tmog_pkg::*;

  localparam int unsigned TICKS       = TICKS_PER_SECOND_DEF;
  localparam int          CYCLE_LIMIT = 1_000_000;
  // Index past the three registers; the core must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int TEMP_LO = -880;
  localparam int TEMP_HI = 2000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the registers and the control state
  logic signed [TEMP_W-1:0] cfg_setpoint;
  logic [DIFF_W-1:0]        cfg_diff;
  logic [SECONDS_W-1:0]     cfg_min_off;
  tmog_flags_t              ctl;
  logic                     guard_on;
  logic [ELAPSED_W-1:0]     guard_ticks;

  // Results still owed by the core, oldest first
  tmog_flags_t expected_q[$];

  int tx_gap_max = 14;
  int rx_gap_max = 14;
  int hold_off_req = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int relay_drops = 0;
  int guard_expiries = 0;
  int cycle_count = 0;

  thermostat_min_off_guard_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [11:0] temperature, [12] temp_valid, [15:13] zero
    .s_tuser   (s_tuser),   // [0] action
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [0] relay, [1] demand, [2] permit, [18:3] wait, [23:19] zero
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[thermostat_min_off_guard_core] ERROR");
      $finish;
    end
  end

  // Advance the predictor by one accepted item and return the result it owes.
  function automatic tmog_flags_t advance_thermostat(input logic act,
                                                     input logic signed [TEMP_W-1:0] temp,
                                                     input logic vld);
    logic        was_on;
    int          t;
    int          sp;
    int          cut_in;
    int unsigned span;
    int unsigned left;
    if (act == ACT_TICK) begin
      // The guard clock runs only while the guard holds, and saturates
      if (guard_on && guard_ticks < ELAPSED_MAX)
        guard_ticks = guard_ticks + 1'b1;
    end else if (!vld) begin
      // A bad reading forces everything off but leaves the guard alone
      ctl = '0;
    end else begin
      was_on = ctl.relay;
      t      = temp;
      sp     = cfg_setpoint;
      cut_in = sp + int'(cfg_diff);
      if (t >= cut_in)
        ctl.demand = 1'b1;
      else if (t <= sp)
        ctl.demand = 1'b0;
      ctl.permit   = 1'b1;
      ctl.wait_sec = '0;
      if (guard_on) begin
        span = cfg_min_off * TICKS;
        if (guard_ticks < span) begin
          left         = span - guard_ticks;
          ctl.permit   = 1'b0;
          ctl.wait_sec = SECONDS_W'((left + TICKS - 1) / TICKS);
        end else begin
          guard_on = 1'b0;
          guard_expiries++;
        end
      end
      ctl.relay = ctl.demand & ctl.permit;
      // Relay dropped: restart the minimum off time from zero
      if (was_on && !ctl.relay) begin
        guard_on     = 1'b1;
        guard_ticks  = '0;
        ctl.permit   = 1'b0;
        ctl.wait_sec = cfg_min_off;
        relay_drops++;
      end
    end
    return ctl;
  endfunction

  function automatic int random_temp();
    return int'($urandom_range(0, TEMP_HI - TEMP_LO)) + TEMP_LO;
  endfunction

  // Offer one item after a random gap, hold it until the transfer, then predict.
  task automatic send_item(input logic act, input logic signed [TEMP_W-1:0] temp,
                           input logic vld);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {3'b000, vld, temp};
    do @(posedge clk); while (s_tready !== 1'b1);
    expected_q.push_back(advance_thermostat(act, temp, vld));
    items_sent++;
  endtask

  task automatic send_eval(input int t);
    send_item(ACT_EVALUATE, t[TEMP_W-1:0], 1'b1);
  endtask

  // Temperature and valid flag carry junk on a tick; the core must ignore them
  task automatic send_tick();
    send_item(ACT_TICK, TEMP_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_invalid();
    int t;
    t = random_temp();
    send_item(ACT_EVALUATE, t[TEMP_W-1:0], 1'b0);
  endtask

  // Drop valid and let every owed result drain before touching the registers.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The leading edge keeps a lowered write enable apart from the next raise
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_SETPOINT:     cfg_setpoint = val[TEMP_W-1:0];
      REG_DIFFERENTIAL: cfg_diff     = val[DIFF_W-1:0];
      REG_MIN_OFF:      cfg_min_off  = val[SECONDS_W-1:0];
      default: ;
    endcase
  endtask

  // Mostly evaluations near the cut-in and cut-out points, with ticks, tick
  // bursts and bad readings mixed in.
  task automatic send_random_item(input int burst_max);
    int pick;
    int t;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      repeat ($urandom_range(1, burst_max)) send_tick();
    end else if (pick < 35) begin
      send_tick();
    end else if (pick < 45) begin
      send_invalid();
    end else begin
      case ($urandom_range(0, 2))
        0:       t = random_temp();
        1:       t = int'(cfg_setpoint) + int'($urandom_range(0, 16)) - 8;
        default: t = int'(cfg_setpoint) + int'(cfg_diff) + int'($urandom_range(0, 16)) - 8;
      endcase
      if (t < TEMP_LO) t = TEMP_LO;
      if (t > TEMP_HI) t = TEMP_HI;
      send_eval(t);
    end
  endtask

  task automatic run_phase(input int sp, input int diff, input int min_off,
                           input int n_items, input int burst_max,
                           input int txg, input int rxg);
    int stop_at;
    wait_idle();
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_DIFFERENTIAL, diff);
    write_reg(REG_MIN_OFF, min_off);
    tx_gap_max = txg;
    rx_gap_max = rxg;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_item(burst_max);
  endtask

  // Reset values: the guard starts at reset, so demand alone cannot close the relay.
  task automatic test_reset_defaults();
    repeat (3) send_tick();
    send_eval(96);       // exactly at cut-in
    send_eval(80);       // inside the band, demand held
    send_eval(64);       // exactly at setpoint, demand released
    send_eval(TEMP_HI);
    send_invalid();
    send_eval(TEMP_LO);
  endtask

  // Hysteresis with no minimum off time: turn-on, hold, drop, restart.
  task automatic test_hysteresis();
    wait_idle();
    write_reg(REG_SETPOINT, 100);
    write_reg(REG_DIFFERENTIAL, 20);
    write_reg(REG_MIN_OFF, 0);
    send_eval(120);      // cut-in, zero guard runs out at once
    send_eval(110);      // held in band
    send_eval(100);      // cut-out, relay drop restarts the guard
    send_eval(119);      // just under cut-in, stays off
    send_eval(120);
    // Bad reading while the relay is closed: forced off, guard not restarted
    send_item(ACT_EVALUATE, 12'sd120, 1'b0);
    send_eval(130);
  endtask

  // Count the guard down tick by tick and check the round-up of wait seconds.
  task automatic test_guard_countdown();
    tx_gap_max = 3;
    rx_gap_max = 3;
    wait_idle();
    write_reg(REG_MIN_OFF, 1);
    send_eval(90);       // relay drop, one second guard
    send_eval(130);      // demand back but blocked
    repeat (500) send_tick();
    send_eval(130);      // half a second left rounds up to one
    repeat (499) send_tick();
    send_eval(130);      // one tick left still reads as one second
    send_tick();
    send_eval(130);      // guard ends, relay closes
  endtask

  // Register extremes and a write to the unused index.
  task automatic test_register_limits();
    tx_gap_max = 14;
    rx_gap_max = 14;
    wait_idle();
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_MIN_OFF, 65535);
    send_eval(TEMP_HI);
    send_eval(TEMP_LO);  // drop with the longest guard
    send_eval(TEMP_HI);  // full guard left, wait at its maximum
    wait_idle();
    write_reg(REG_SETPOINT, TEMP_LO);
    write_reg(REG_DIFFERENTIAL, 0);
    write_reg(REG_MIN_OFF, 0);
    send_eval(TEMP_LO);  // cut-in equals cut-out, turn-on wins
    send_eval(TEMP_LO + 1);
    wait_idle();
    write_reg(REG_SETPOINT, TEMP_HI);
    write_reg(REG_DIFFERENTIAL, 1600);
    send_eval(TEMP_HI);  // cut-in beyond any reading
    send_eval(TEMP_HI - 1);
  endtask

  // Stall the result side long enough for the core to back up into its input.
  task automatic test_backpressure();
    wait_idle();
    tx_gap_max   = 0;
    rx_gap_max   = 0;
    hold_off_req = 300;
    repeat (60) send_random_item(4);
  endtask

  task automatic test_random();
    run_phase(64, 32, 0, 50, 8, 0, 0);
    run_phase(TEMP_LO, 0, 0, 40, 8, 14, 14);
    run_phase(TEMP_HI, 1600, 1, 40, 8, 14, 0);
    run_phase(random_temp(), $urandom_range(0, 1600), 1, 50, 8, 3, 3);
    run_phase(random_temp(), $urandom_range(0, 1600), 65535, 30, 8, 0, 14);
    run_phase(0, 1, 2, 40, 8, 14, 14);
    run_phase(random_temp(), $urandom_range(0, 1600), $urandom_range(0, 3), 50, 8, 7, 7);
  endtask

  // Result side: random stalls per result, one long hold-off on request,
  // and a field-by-field check of every transfer.
  initial begin : result_checker
    int          stall;
    tmog_flags_t want;
    tmog_flags_t got;
    m_tready <= 1'b0;
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    forever begin
      if (hold_off_req > 0) begin
        stall        = hold_off_req;
        hold_off_req = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got.relay    = m_tdata[0];
      got.demand   = m_tdata[1];
      got.permit   = m_tdata[2];
      got.wait_sec = m_tdata[18:3];
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing owed: %s %0b %0b %0b wait %0d",
                   results_checked, "relay/demand/permit", got.relay, got.demand,
                   got.permit, got.wait_sec);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d: expected relay %0b demand %0b permit %0b wait %0d,",
                      " got relay %0b demand %0b permit %0b wait %0d"},
                     results_checked, want.relay, want.demand, want.permit,
                     want.wait_sec, got.relay, got.demand, got.permit, got.wait_sec);
        end
      end
    end
  end

  initial begin : stimulus
    // Drive every input from time zero with reset held
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= ACT_EVALUATE;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SETPOINT;
    cfg_data  <= '0;
    // Predictor starts from the reset state of the core
    cfg_setpoint = SETPOINT_RST;
    cfg_diff     = DIFFERENTIAL_RST;
    cfg_min_off  = MIN_OFF_RST;
    ctl          = '0;
    ctl.wait_sec = MIN_OFF_RST;
    guard_on     = 1'b1;
    guard_ticks  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_hysteresis();
    test_guard_countdown();
    test_register_limits();
    test_backpressure();
    test_random();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d items and checked %0d results over %0d cycles.",
             items_sent, results_checked, cycle_count);
    $display("Predictor saw %0d relay drops and %0d guard expiries; %0d mismatches.",
             relay_drops, guard_expiries, mismatch_count);
    if (mismatch_count == 0 && expected_q.size() == 0)
      $display("[thermostat_min_off_guard_core] OK");
    else
      $display("[thermostat_min_off_guard_core] ERROR");
    $finish;
  end

endmodule

/* sim.f */
src/tmog_pkg.sv
src/tmog_guard.sv
src/tmog_ctrl.sv
src/thermostat_min_off_guard_core.sv
tb/sv/thermostat_min_off_guard_core_tb.sv
